[rtl/bsd_pkg.sv]
// bsd_pkg: shared types and constants for the bit stuffing / destuffing codec
// no dependencies; imported by every module of the codec
`timescale 1ns / 1ps

package bsd_pkg;

	// fixed field widths
	localparam int BYTE_BITS       = 8;
	localparam int RUN_W           = 3;
	localparam int GATHER_W        = $clog2(BYTE_BITS);
	localparam int REM_W           = $clog2(BYTE_BITS + 1);
	localparam int MAX_RESULTS     = 10;
	localparam int NRES_W          = $clog2(MAX_RESULTS + 1);
	localparam int RUN_LENGTH_DEF  = 5;

	// result kind codes
	localparam logic KIND_LINE_BIT = 1'b0;
	localparam logic KIND_BYTE     = 1'b1;

	// direction register codes
	localparam logic DIR_STUFF     = 1'b0;
	localparam logic DIR_DESTUFF   = 1'b1;

	// operation chosen by the front for each transaction
	typedef enum logic {
		OP_STUFF   = 1'b0,
		OP_DESTUFF = 1'b1
	} op_t;

	// classified input transaction between front and back
	typedef struct packed {
		op_t                  op;
		logic [BYTE_BITS-1:0] in_byte;
		logic                 in_bit;
		logic                 som;
	} item_t;

	// one result transaction
	typedef struct packed {
		logic                 kind;
		logic                 out_bit;
		logic [BYTE_BITS-1:0] out_byte;
		logic                 last;
	} result_t;

	// handshake between the back and the result queue
	typedef struct packed {
		logic    valid;
		result_t data;
	} res_push_t;

endpackage

[rtl/bsd_front.sv]
// bsd_front: input side of the codec; holds the direction register, tags each
// transaction with its operation and keeps it in a two-entry queue. uses bsd_pkg
`timescale 1ns / 1ps

module bsd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	// input transaction channel
	input  logic                          push,
	output logic                          full,
	input  logic [bsd_pkg::BYTE_BITS-1:0] in_byte,
	input  logic                          in_bit,
	input  logic                          start_of_message,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	// towards the back
	output logic                          q_valid,
	output bsd_pkg::item_t                q_item,
	input  logic                          q_take
);
	import bsd_pkg::*;

	logic      direction_q;
	item_t     entry_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] cnt_q;
	logic      do_push;
	logic      do_pop;
	item_t     new_item;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_STUFF;
		end else if (cfg_valid) begin
			direction_q <= cfg_data;
		end
	end

	// classify the incoming transaction by direction
	always_comb begin
		new_item.op      = (direction_q == DIR_DESTUFF) ? OP_DESTUFF : OP_STUFF;
		new_item.in_byte = in_byte;
		new_item.in_bit  = in_bit;
		new_item.som     = start_of_message;
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("input queue overfilled");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("back took from an empty input queue");

	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("input queue level not tracking pushes");

endmodule

[rtl/bsd_back.sv]
// bsd_back: run-length engine; stuffs one line bit per cycle while the result
// queue has room, or destuffs one line bit per transaction, and keeps the shared run state. uses bsd_pkg
`timescale 1ns / 1ps

module bsd_back #(
	parameter int RUN_LENGTH = bsd_pkg::RUN_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// from the front
	input  logic               q_valid,
	input  bsd_pkg::item_t     q_item,
	output logic               q_take,
	// towards the result queue
	output bsd_pkg::res_push_t res,
	input  logic               res_ready
);
	import bsd_pkg::*;

	localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(RUN_LENGTH);

	// run and receive state
	logic [RUN_W-1:0]     run_q,   run_n;
	logic                 skip_q,  skip_n;
	logic [BYTE_BITS-1:0] shift_q, shift_n;
	logic [GATHER_W-1:0]  cnt_q,   cnt_n;
	// transmit sequencer
	logic                 busy_q,  busy_n;
	logic                 pend_q,  pend_n;
	logic [REM_W-1:0]     rem_q,   rem_n;
	logic [NRES_W-1:0]    nres_q,  nres_n;
	logic [BYTE_BITS-1:0] byte_q,  byte_n;

	// working values, taken from the new transaction on its first cycle
	logic                 start;
	logic                 clr;
	logic                 stuff_go;
	logic                 destuff_go;
	logic [RUN_W-1:0]     w_run;
	logic                 w_skip;
	logic [BYTE_BITS-1:0] w_shift;
	logic [GATHER_W-1:0]  w_cnt;
	logic                 w_pend;
	logic [REM_W-1:0]     w_rem;
	logic [NRES_W-1:0]    w_nres;
	logic [BYTE_BITS-1:0] w_byte;
	logic [RUN_W-1:0]     run_c;
	logic [BYTE_BITS-1:0] shift_c;
	logic                 stuffed;
	logic                 fin;
	logic                 emit;

	function automatic logic [RUN_W-1:0] run_q_inc(input logic [RUN_W-1:0] r);
		return r + RUN_W'(1);
	endfunction

	// next state and result
	always_comb begin
		start      = !busy_q && q_valid && res_ready;
		clr        = start && q_item.som;
		stuff_go   = (start && q_item.op == OP_STUFF) || (busy_q && res_ready);
		destuff_go = start && q_item.op == OP_DESTUFF;
		q_take     = start;

		w_run   = clr ? '0 : run_q;
		w_skip  = clr ? 1'b0 : skip_q;
		w_shift = clr ? '0 : shift_q;
		w_cnt   = clr ? '0 : cnt_q;
		w_pend  = start ? 1'b0 : pend_q;
		w_rem   = start ? REM_W'(BYTE_BITS) : rem_q;
		w_nres  = start ? '0 : nres_q;
		w_byte  = start ? q_item.in_byte : byte_q;

		run_n   = start ? w_run : run_q;
		skip_n  = start ? w_skip : skip_q;
		shift_n = start ? w_shift : shift_q;
		cnt_n   = start ? w_cnt : cnt_q;
		busy_n  = busy_q;
		pend_n  = pend_q;
		rem_n   = rem_q;
		nres_n  = nres_q;
		byte_n  = byte_q;

		run_c   = '0;
		shift_c = '0;
		stuffed = 1'b0;
		fin     = 1'b0;
		emit    = 1'b0;

		res.valid         = 1'b0;
		res.data.kind     = KIND_LINE_BIT;
		res.data.out_bit  = 1'b0;
		res.data.out_byte = '0;
		res.data.last     = 1'b0;

		if (stuff_go) begin
			// one line bit: a stuffed zero if pending, else the next data bit
			if (w_pend) begin
				fin              = (w_rem == '0);
				pend_n           = 1'b0;
				res.data.out_bit = 1'b0;
			end else begin
				run_c            = w_byte[BYTE_BITS-1] ? run_q_inc(w_run) : '0;
				stuffed          = (run_c == RUN_MAX);
				run_n            = stuffed ? '0 : run_c;
				pend_n           = stuffed;
				rem_n            = w_rem - REM_W'(1);
				byte_n           = {w_byte[BYTE_BITS-2:0], 1'b0};
				fin              = (w_rem == REM_W'(1)) && !stuffed;
				res.data.out_bit = w_byte[BYTE_BITS-1];
			end
			emit          = (w_nres < NRES_W'(MAX_RESULTS));
			res.valid     = emit;
			res.data.last = fin || (w_nres == NRES_W'(MAX_RESULTS - 1));
			nres_n        = emit ? w_nres + NRES_W'(1) : w_nres;
			busy_n        = !fin;
		end else if (destuff_go) begin
			// one received bit: drop it after a full run, else gather it
			if (w_skip) begin
				skip_n = 1'b0;
			end else begin
				shift_c = {w_shift[BYTE_BITS-2:0], q_item.in_bit};
				run_c   = q_item.in_bit ? run_q_inc(w_run) : '0;
				stuffed = (run_c == RUN_MAX);
				run_n   = stuffed ? '0 : run_c;
				skip_n  = stuffed;
				if (w_cnt == GATHER_W'(BYTE_BITS - 1)) begin
					res.valid         = 1'b1;
					res.data.kind     = KIND_BYTE;
					res.data.out_byte = shift_c;
					res.data.last     = 1'b1;
					cnt_n             = '0;
					shift_n           = '0;
				end else begin
					cnt_n   = w_cnt + GATHER_W'(1);
					shift_n = shift_c;
				end
			end
		end
	end

	// control and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			skip_q  <= 1'b0;
			shift_q <= '0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			pend_q  <= 1'b0;
			rem_q   <= '0;
			nres_q  <= '0;
		end else begin
			run_q   <= run_n;
			skip_q  <= skip_n;
			shift_q <= shift_n;
			cnt_q   <= cnt_n;
			busy_q  <= busy_n;
			pend_q  <= pend_n;
			rem_q   <= rem_n;
			nres_q  <= nres_n;
		end
	end

	// byte being sent out
	always_ff @(posedge clk) begin
		byte_q <= byte_n;
	end

	a_byte_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.kind == KIND_BYTE) |-> res.data.last)
		else $error("recovered byte not marked last");

	a_nres_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= NRES_W'(MAX_RESULTS))
		else $error("result count past its limit");

	a_busy_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0 || pend_q))
		else $error("sequencer busy with nothing left to send");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!res_ready |-> !res.valid)
		else $error("result pushed into a full queue");

endmodule

[rtl/bsd_outq.sv]
// bsd_outq: two-entry result queue between the back and the result ports
// uses bsd_pkg for the result types
`timescale 1ns / 1ps

module bsd_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	// from the back
	input  bsd_pkg::res_push_t            res,
	output logic                          res_ready,
	// result channel
	output logic                          empty,
	input  logic                          pop,
	output logic                          kind,
	output logic                          out_bit,
	output logic [bsd_pkg::BYTE_BITS-1:0] out_byte,
	output logic                          last
);
	import bsd_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;
	result_t    head;

	assign res_ready = (cnt_q != 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign do_push   = res.valid && res_ready;
	assign do_pop    = pop && !empty;

	// head of queue onto the ports
	assign head     = entry_q[rd_ptr_q];
	assign kind     = head.kind;
	assign out_bit  = head.out_bit;
	assign out_byte = head.out_byte;
	assign last     = head.last;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= res.data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue overfilled");

	a_ptr_level: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("result queue pointers disagree with level");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1 && do_pop && !do_push) |=> empty)
		else $error("result queue not empty after last pop");

endmodule

[rtl/bit_stuff_destuff_codec.sv]
// bit_stuff_destuff_codec: top level of the five-ones bit stuffing codec
// depends on bsd_pkg, bsd_front, bsd_back and bsd_outq
//
//   channel   handshake            payload
//   input     push / full          in_byte, in_bit, start_of_message
//   result    empty / pop          kind, out_bit, out_byte, last
//   config    cfg_valid/cfg_ready  cfg_data (direction)
//
// transmit: a byte gives 8 to 10 line bits, one per cycle while the result
//   queue has room; the next byte is taken only after the last bit is sent
// receive: one line bit, one transaction per cycle while results can be queued
// two-entry queues on both sides let input and results stall independently
// reset clears the run state, partial byte, queues and the direction (stuff)
`timescale 1ns / 1ps

module bit_stuff_destuff_codec #(
	parameter int RUN_LENGTH = bsd_pkg::RUN_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          push,
	output logic                          full,
	input  logic [bsd_pkg::BYTE_BITS-1:0] in_byte,
	input  logic                          in_bit,
	input  logic                          start_of_message,
	// result channel
	output logic                          empty,
	input  logic                          pop,
	output logic                          kind,
	output logic                          out_bit,
	output logic [bsd_pkg::BYTE_BITS-1:0] out_byte,
	output logic                          last,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);
	import bsd_pkg::*;

	logic      q_valid;
	item_t     q_item;
	logic      q_take;
	res_push_t res;
	logic      res_ready;

	// accept and classify
	bsd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.in_byte          (in_byte),
		.in_bit           (in_bit),
		.start_of_message (start_of_message),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_take           (q_take)
	);

	// stuff / destuff engine
	bsd_back #(
		.RUN_LENGTH (RUN_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take),
		.res       (res),
		.res_ready (res_ready)
	);

	// result queue
	bsd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.out_bit   (out_bit),
		.out_byte  (out_byte),
		.last      (last)
	);

	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		(RUN_LENGTH >= 2) && (RUN_LENGTH <= 7))
		else $error("run length outside its supported range");

	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_BYTE) |-> !out_bit)
		else $error("byte result carries a line bit");

	a_bit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_LINE_BIT) |-> (out_byte == '0))
		else $error("line bit result carries a byte");

endmodule
